[design/phit_pkg.sv]
`default_nettype none

package phit_pkg;

	localparam int MAX_FIGURES = 16;
	localparam int COORD_BITS  = 24;
	localparam int FIG_IDX_W   = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
	localparam int FIG_CNT_W   = $clog2(MAX_FIGURES + 1);
	localparam int POINT_W     = 16;
	localparam int FIG_NUM_W   = 5;
	localparam int PROD_W      = 2 * COORD_BITS;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [POINT_W-1:0] POINT_MAX = {POINT_W{1'b1}};

	typedef struct packed {
		logic                         kind;
		logic                         is_circle;
		logic signed [COORD_BITS-1:0] coord_a;
		logic signed [COORD_BITS-1:0] coord_b;
		logic signed [COORD_BITS-1:0] coord_c;
		logic signed [COORD_BITS-1:0] coord_d;
	} req_t;

	typedef struct packed {
		logic [POINT_W-1:0]   point_number;
		logic [FIG_NUM_W-1:0] figure_number;
		logic                 contained;
		logic                 last;
	} rsp_t;

	typedef struct packed {
		logic                         is_circle;
		logic signed [COORD_BITS-1:0] x_first;
		logic signed [COORD_BITS-1:0] y_first;
		logic signed [COORD_BITS-1:0] x_second;
		logic signed [COORD_BITS-1:0] y_second;
	} figure_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_C_DY,
		ST_C_R,
		ST_C_SUM,
		ST_C_CMP,
		ST_NEXT,
		ST_DONE
	} state_t;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic [COORD_BITS:0] d;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		if (d[COORD_BITS]) begin
			d = ~d + 1'b1;
		end
		return d[COORD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

[design/phit_if.sv]
`default_nettype none

interface phit_in_if import phit_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface phit_out_if import phit_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/phit_table.sv]
`default_nettype none

module phit_table import phit_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [FIG_IDX_W-1:0] wr_idx,
	input  wire figure_t              wr_entry,
	input  wire logic [FIG_IDX_W-1:0] rd_idx,
	output figure_t                   rd_entry
);

	figure_t entries_q [MAX_FIGURES];
	figure_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_idx] <= wr_entry;
		end
		rd_q <= entries_q[rd_idx];
	end

	assign rd_entry = rd_q;

endmodule

`default_nettype wire

[design/point_in_figures_hit_test_core.sv]
// Channel  Direction  Payload                                         Role
// req      in         kind, is_circle, coord_a .. coord_d             add figure or query point
// rsp      out        point_number, figure_number, contained, last    one hit, or one miss
//
// An add request is taken in ST_IDLE. A query then walks each figure: a rectangle
// passes EVAL and NEXT, a circle EVAL, C_DY, C_R, C_SUM, C_CMP and NEXT, where the
// single shared squarer is used three times, and the DONE state closes the result run.
// A held result stalls the figure walk until the sink takes it; req is not ready
// while a query is in progress. Reset clears the figure count and the point counter.
`default_nettype none

module point_in_figures_hit_test_core import phit_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	phit_in_if.sink    req,
	phit_out_if.source rsp
);

	state_t state_q, state_d;

	logic [FIG_CNT_W-1:0]  total_q;
	logic [FIG_IDX_W-1:0]  idx_q;
	logic [FIG_IDX_W-1:0]  idx_d;
	logic [POINT_W-1:0]    qnum_q;
	logic                  pend_valid_q;
	logic [FIG_NUM_W-1:0]  pend_num_q;
	logic                  out_valid_q;
	rsp_t                  out_data_q;

	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [COORD_BITS-1:0]        op_q;
	logic [PROD_W-1:0]            prod_q;
	logic [PROD_W:0]              sum_q;
	logic                         hit_q;

	logic              accept, accept_add, accept_query, table_wr;
	logic              out_free, last_fig, stall, push;
	rsp_t              push_data;
	figure_t           fig, new_fig;
	logic [PROD_W-1:0] prod_d;
	logic              rect_hit;

	assign new_fig = '{
		is_circle: req.data.is_circle,
		x_first:   req.data.coord_a,
		y_first:   req.data.coord_b,
		x_second:  req.data.coord_c,
		y_second:  req.data.coord_d
	};

	phit_table u_table (
		.clk      (clk),
		.wr_en    (table_wr),
		.wr_idx   (total_q[FIG_IDX_W-1:0]),
		.wr_entry (new_fig),
		.rd_idx   (idx_d),
		.rd_entry (fig)
	);

	assign prod_d   = op_q * op_q;
	assign rect_hit = (px_q > fig.x_first) && (px_q < fig.x_second) &&
		(py_q < fig.y_first) && (py_q > fig.y_second);
	assign last_fig = (FIG_CNT_W'(idx_q) + 1'b1) == total_q;
	assign out_free = !out_valid_q || rsp.ready;

	// Outputs of the sequencer.
	always_comb begin
		req.ready    = (state_q == ST_IDLE);
		accept       = req.valid && req.ready;
		accept_add   = accept && (req.data.kind == KIND_ADD);
		accept_query = accept && (req.data.kind == KIND_QUERY);
		table_wr     = accept_add && (total_q < FIG_CNT_W'(MAX_FIGURES));
		stall        = 1'b0;
		push         = 1'b0;
		push_data    = '{point_number: qnum_q, figure_number: pend_num_q,
			contained: 1'b1, last: 1'b0};
		unique case (state_q)
			ST_NEXT: begin
				if (hit_q && pend_valid_q) begin
					stall = !out_free;
					push  = out_free;
				end
			end
			ST_DONE: begin
				stall = !out_free;
				push  = out_free;
				if (pend_valid_q) begin
					push_data.last = 1'b1;
				end else begin
					push_data = '{point_number: qnum_q, figure_number: '0,
						contained: 1'b0, last: 1'b1};
				end
			end
			default: begin
			end
		endcase
		idx_d = idx_q;
		if (accept_query) begin
			idx_d = '0;
		end else if (state_q == ST_NEXT && !stall) begin
			idx_d = idx_q + 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept_query) begin
					state_d = (total_q == '0) ? ST_DONE : ST_EVAL;
				end
			end
			ST_EVAL:  state_d = fig.is_circle ? ST_C_DY : ST_NEXT;
			ST_C_DY:  state_d = ST_C_R;
			ST_C_R:   state_d = ST_C_SUM;
			ST_C_SUM: state_d = ST_C_CMP;
			ST_C_CMP: state_d = ST_NEXT;
			ST_NEXT: begin
				if (!stall) begin
					state_d = last_fig ? ST_DONE : ST_EVAL;
				end
			end
			ST_DONE: begin
				if (!stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			total_q      <= '0;
			idx_q        <= '0;
			qnum_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (table_wr) begin
				total_q <= total_q + 1'b1;
			end
			if (accept_query) begin
				pend_valid_q <= 1'b0;
				qnum_q       <= (qnum_q == POINT_MAX) ? POINT_W'(1) : qnum_q + 1'b1;
			end
			if (state_q == ST_NEXT && !stall) begin
				if (hit_q) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_query) begin
			px_q <= req.data.coord_a;
			py_q <= req.data.coord_b;
		end
		if (push) begin
			out_data_q <= push_data;
		end
		if (state_q == ST_NEXT && !stall && hit_q) begin
			pend_num_q <= FIG_NUM_W'(FIG_CNT_W'(idx_q) + 1'b1);
		end
		case (state_q)
			ST_EVAL: begin
				hit_q <= rect_hit;
				op_q  <= abs_diff(px_q, fig.x_first);
			end
			ST_C_DY: begin
				prod_q <= prod_d;
				op_q   <= abs_diff(py_q, fig.y_first);
			end
			ST_C_R: begin
				sum_q  <= {1'b0, prod_q};
				prod_q <= prod_d;
				op_q   <= abs_diff(fig.x_second, '0);
			end
			ST_C_SUM: begin
				sum_q  <= sum_q + {1'b0, prod_q};
				prod_q <= prod_d;
			end
			ST_C_CMP: begin
				hit_q <= sum_q < {1'b0, prod_q};
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

endmodule

`default_nettype wire
